### hdl/hvn_pkg.sv
`default_nettype none
package hvn_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam logic [31:0] MixMulA = 32'h7feb352d;
  localparam logic [31:0] MixMulB = 32'h846ca68b;
  localparam logic [31:0] CxMul = 32'h9e3779b9;
  localparam logic [31:0] CyMul = 32'h85ebca6b;
  localparam logic [31:0] CyAdd = 32'h1b873593;
  localparam logic [24:0] ValOffset = 25'h1000000;
endpackage
`default_nettype wire

### hdl/hashed_value_noise_2d.sv
`default_nettype none
// channel | dir | tdata fields (lsb first)
// s_axis  | in  | point_x[31:0], point_y[63:32], salt[95:64]
// m_axis  | out | noise_value[24:0], zero pad to 32 bits
// cfg     | in  | world_seed[31:0]
// one point per cycle while m_axis does not stall; two input stages, three mixes in
// series of three stages each, a key stage, a corner stage and six blend stages
// (the smoothstep runs beside the corner stage and the first blend stage).
// rst_ni clears world_seed and the stage valid bits only.
// a stall at m_axis freezes the whole pipe; a held result is never lost.
module hashed_value_noise_2d #(
  parameter int unsigned FRACTION_BITS = hvn_pkg::FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // point_x, point_y, salt
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // noise_value, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import hvn_pkg::*;

  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned NS = 19;
  localparam int unsigned SW = F + 2;

  logic [31:0] seed_q;
  logic        adv;
  logic [NS-1:0] vld_q;

  assign adv = ~vld_q[NS-1] | m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_valid) seed_q <= cfg_data;
      if (adv) vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  // hash lanes: 0 cx,1 cx1,2 cy,3 cy1,4 seed+salt
  // each mix takes 3 stages: xs16+mul, xs15+mul, xs16
  function automatic logic [31:0] xs(input logic [31:0] v, input int unsigned sh);
    return v ^ (v >> sh);
  endfunction

  // stage 0: cells, fractions, pre-multiply inputs
  logic [31:0] pre_q [5];
  logic [F-1:0] fx_q [12];
  logic [F-1:0] fy_q [12];
  logic [31:0] cx, cy;
  logic [31:0] px, py;
  assign px = s_axis_tdata[31:0];
  assign py = s_axis_tdata[63:32];
  assign cx = 32'($signed(px) >>> F);
  assign cy = 32'($signed(py) >>> F);

  // stage 1: lane multiplies
  logic [31:0] l1_q [5];
  // mix pipeline for first level: stages 2..4
  logic [31:0] ma_q [5], mb_q [5], mc_q [5];
  // stage 5: combine keys (4 corners)
  logic [31:0] k_q [4];
  // second-level mix of key: 6..8, third mix: 9..11
  logic [31:0] na_q [4], nb_q [4], nc_q [4];
  logic [31:0] oa_q [4], ob_q [4], oc_q [4];
  // corner values stage 12
  logic signed [25:0] cv_q [4];
  // smoothstep pipe
  logic [2*F-1:0] sqx_q, sqy_q;
  logic [SW-1:0] gx_q, gy_q;
  logic [F-1:0] sx_q;
  logic [F-1:0] sy_q [4];
  // blend
  logic signed [26:0] dlo_q, dhi_q;
  logic signed [25:0] a_lo_q, a_hi_q, lo_q, hi_q, blo_q;
  logic signed [26:0] dy_q;
  logic signed [26+F:0] plo_q, phi_q, py_q;
  logic signed [24:0] res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // s0
      pre_q[0] <= cx;
      pre_q[1] <= cx + 32'd1;
      pre_q[2] <= cy;
      pre_q[3] <= cy + 32'd1;
      pre_q[4] <= seed_q + s_axis_tdata[95:64];
      fx_q[0] <= px[F-1:0];
      fy_q[0] <= py[F-1:0];
      for (int i = 1; i < 12; i++) begin
        fx_q[i] <= fx_q[i-1];
        fy_q[i] <= fy_q[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        sy_q[i] <= sy_q[i-1];
      end
      // s1
      l1_q[0] <= pre_q[0] * CxMul;
      l1_q[1] <= pre_q[1] * CxMul;
      l1_q[2] <= pre_q[2] * CyMul + CyAdd;
      l1_q[3] <= pre_q[3] * CyMul + CyAdd;
      l1_q[4] <= pre_q[4];
      for (int i = 0; i < 5; i++) begin
        ma_q[i] <= xs(l1_q[i], 16) * MixMulA;
        mb_q[i] <= xs(ma_q[i], 15) * MixMulB;
        mc_q[i] <= xs(mb_q[i], 16);
      end
      k_q[0] <= mc_q[0] ^ mc_q[2] ^ mc_q[4];
      k_q[1] <= mc_q[1] ^ mc_q[2] ^ mc_q[4];
      k_q[2] <= mc_q[0] ^ mc_q[3] ^ mc_q[4];
      k_q[3] <= mc_q[1] ^ mc_q[3] ^ mc_q[4];
      for (int i = 0; i < 4; i++) begin
        na_q[i] <= xs(k_q[i], 16) * MixMulA;
        nb_q[i] <= xs(na_q[i], 15) * MixMulB;
        nc_q[i] <= xs(nb_q[i], 16);
        oa_q[i] <= xs(nc_q[i], 16) * MixMulA;
        ob_q[i] <= xs(oa_q[i], 15) * MixMulB;
        oc_q[i] <= xs(ob_q[i], 16);
        cv_q[i] <= $signed({1'b0, oc_q[i][23:0], 1'b0}) - $signed({1'b0, ValOffset});
      end
      // smoothstep from stored fraction, stages 12..13 (exact floor)
      sqx_q <= fx_q[11] * fx_q[11];
      sqy_q <= fy_q[11] * fy_q[11];
      gx_q <= SW'((3 << F)) - {1'b0, fx_q[11], 1'b0};
      gy_q <= SW'((3 << F)) - {1'b0, fy_q[11], 1'b0};
      sx_q <= F'(((3*F+2)'(sqx_q) * gx_q) >> (2*F));
      sy_q[0] <= F'(((3*F+2)'(sqy_q) * gy_q) >> (2*F));
      // corner values held one stage, in step with the smoothstep
      a_lo_q <= cv_q[0];
      a_hi_q <= cv_q[2];
      dlo_q <= 27'(cv_q[1]) - 27'(cv_q[0]);
      dhi_q <= 27'(cv_q[3]) - 27'(cv_q[2]);
      // s14: x products
      plo_q <= ((27+F)'(a_lo_q) <<< F) + dlo_q * $signed({1'b0, sx_q});
      phi_q <= ((27+F)'(a_hi_q) <<< F) + dhi_q * $signed({1'b0, sx_q});
      // s15: floor
      lo_q <= 26'(plo_q >>> F);
      hi_q <= 26'(phi_q >>> F);
      // s16: y diff
      blo_q <= lo_q;
      dy_q <= 27'(hi_q) - 27'(lo_q);
      // s17, s18
      py_q <= ((27+F)'(blo_q) <<< F) + dy_q * $signed({1'b0, sy_q[3]});
      res_q <= 25'(py_q >>> F);
    end
  end

  assign m_axis_tdata = {7'd0, res_q};
endmodule
`default_nettype wire
